// ----- hw/rtl/ffsa_pkg.sv -----
// Shared types and constants for the free frame stack allocator.
`default_nettype none
package ffsa_pkg;

  localparam int unsigned STACK_DEPTH = 32768;
  localparam int unsigned FRAME_BYTES = 4096;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned FRAME_SHIFT = $clog2(FRAME_BYTES);
  localparam int unsigned ADDR_BITS   = 64;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_REGION = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [0:0]       CFG_VIRTUAL_OFFSET   = 1'd0;
  localparam logic [0:0]       CFG_REGION_FRAME_CAP = 1'd1;
  localparam logic [CNT_W-1:0] CAP_RESET            = 16'd30000;
  localparam logic [CNT_W-1:0] COUNT_FULL           = CNT_W'(STACK_DEPTH);

  typedef struct packed {
    logic [1:0]           command;
    logic [ADDR_BITS-1:0] frame_address;
    logic [ADDR_BITS-1:0] region_length;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] mapped_address;
    logic [1:0]           status;
    logic [CNT_W-1:0]     free_count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic start;        // clear result for a new transaction
    logic push_input;   // write input address at top
    logic pop_read;     // decrement count, read new top
    logic pop_sum;      // add virtual offset to read data
    logic latch_region; // load region base and frame count
    logic region_push;  // push one region frame
    logic set_empty;
    logic set_full;
    logic publish;      // move result into output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic remain_zero;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_POP_SUM = 4'b0010,
    S_REGION  = 4'b0100,
    S_PUBLISH = 4'b1000
  } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/free_frame_stack_allocator_top.sv -----
// Top level of the free frame stack allocator.
// Accept to out_valid: push / no-op go to S_PUBLISH, pop via S_POP_SUM, add-region via S_REGION.
// One transaction in flight; next accept the cycle after the result is registered.
// Pace set by the sequencer; S_PUBLISH waits while the output register is full and not taken.
// Reset (rst_n, sync, active low): stack empty, virtual_offset 0, region_frame_cap 30000.
// The frame store is not cleared; only entries below the count are ever read.
`default_nettype none
module free_frame_stack_allocator_top
  import ffsa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [0:0]           cfg_index,
  input  wire logic [ADDR_BITS-1:0] cfg_wdata,
  // command transactions
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  // result transactions
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data
);

  // Controller decides what happens each cycle; datapath holds all storage.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  ffsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Output register decouples result transactions from the sequencer:
  // a finished result waits there while the next command is accepted.
  ffsa_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_data  (out_data),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/ffsa_datapath.sv -----
// Datapath: frame store memory, stack count, region walker, output register.
`default_nettype none
module ffsa_datapath
  import ffsa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [0:0]           cfg_index,
  input  wire logic [ADDR_BITS-1:0] cfg_wdata,
  input  wire in_item_t             in_data,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  output logic                      out_valid,
  input  wire dp_cmd_t              cmd,
  output dp_stat_t                  stat
);

  logic [ADDR_BITS-1:0] mem [0:STACK_DEPTH-1];
  logic [ADDR_BITS-1:0] rd_data_r;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     count_dec;
  logic [ADDR_BITS-1:0] offset_r;
  logic [CNT_W-1:0]     cap_r;
  logic [ADDR_BITS-1:0] region_addr_r;
  logic [CNT_W-1:0]     remain_r;
  logic [ADDR_BITS-1:0] mapped_r;
  logic [1:0]           status_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_data;
  logic [ADDR_BITS-1:0] frames_req;
  logic [CNT_W-1:0]     frames_cap;

  assign count_dec  = count_r - CNT_W'(1);
  assign wr_en      = cmd.push_input | cmd.region_push;
  assign wr_data    = cmd.push_input ? in_data.frame_address : region_addr_r;
  assign frames_req = in_data.region_length >> FRAME_SHIFT;
  assign frames_cap = (frames_req > ADDR_BITS'(cap_r)) ? cap_r : frames_req[CNT_W-1:0];

  always_comb begin
    count_nxt = count_r;
    if (wr_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop_read) begin
      count_nxt = count_dec;
    end
  end

  // frame store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[ADDR_W-1:0]] <= wr_data;
    end
    if (cmd.pop_read) begin
      rd_data_r <= mem[count_dec[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      offset_r    <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VIRTUAL_OFFSET:   offset_r <= cfg_wdata;
          CFG_REGION_FRAME_CAP: cap_r    <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mapped_r <= '0;
      status_r <= ST_OK;
    end
    if (cmd.set_empty) begin
      status_r <= ST_EMPTY;
    end
    if (cmd.set_full) begin
      status_r <= ST_FULL;
    end
    if (cmd.pop_sum) begin
      mapped_r <= rd_data_r + offset_r;
    end
    if (cmd.latch_region) begin
      region_addr_r <= in_data.frame_address;
      remain_r      <= frames_cap;
    end else if (cmd.region_push) begin
      region_addr_r <= region_addr_r + ADDR_BITS'(FRAME_BYTES);
      remain_r      <= remain_r - CNT_W'(1);
    end
    if (cmd.publish) begin
      out_data_r.mapped_address <= mapped_r;
      out_data_r.status         <= status_r;
      out_data_r.free_count     <= count_r;
    end
  end

  assign stat.count_zero  = (count_r == '0);
  assign stat.count_full  = (count_r == COUNT_FULL);
  assign stat.remain_zero = (remain_r == '0);
  assign stat.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- hw/rtl/ffsa_ctrl.sv -----
// Controller state machine: sequences push, pop, region walk and publish.
`default_nettype none
module ffsa_ctrl
  import ffsa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_command,
  output logic            in_ready,
  input  wire dp_stat_t   stat,
  output dp_cmd_t         cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_PUBLISH;
          unique case (in_command)
            CMD_PUSH: begin
              if (stat.count_full) cmd.set_full   = 1'b1;
              else                 cmd.push_input = 1'b1;
            end
            CMD_POP: begin
              if (stat.count_zero) begin
                cmd.set_empty = 1'b1;
              end else begin
                cmd.pop_read = 1'b1;
                state_nxt    = S_POP_SUM;
              end
            end
            CMD_REGION: begin
              cmd.latch_region = 1'b1;
              state_nxt        = S_REGION;
            end
            default: ;
          endcase
        end
      end
      S_POP_SUM: begin
        cmd.pop_sum = 1'b1;
        state_nxt   = S_PUBLISH;
      end
      S_REGION: begin
        priority if (stat.remain_zero) begin
          state_nxt = S_PUBLISH;
        end else if (stat.count_full) begin
          cmd.set_full = 1'b1;
          state_nxt    = S_PUBLISH;
        end else begin
          cmd.region_push = 1'b1;
        end
      end
      S_PUBLISH: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sim/tb_free_frame_stack_allocator_top.sv -----
// Self-checking testbench for the free frame stack allocator top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_free_frame_stack_allocator_top;
  import ffsa_pkg::*;

  // Unused command code; the block treats it as a no-op.
  localparam logic [1:0] CMD_NOP = 2'd3;
  // Watchdog limit; a correct run ends well before it.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [0:0]           cfg_index = '0;
  logic [ADDR_BITS-1:0] cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;

  free_frame_stack_allocator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the allocator: free frame stack, frame count and both registers.
  // ---------------------------------------------------------------------------
  logic [ADDR_BITS-1:0] frame_mem [STACK_DEPTH];
  int unsigned          held = 0;
  logic [ADDR_BITS-1:0] va_offset = '0;
  logic [CNT_W-1:0]     frame_cap = CAP_RESET;

  in_item_t  cmd_q [$];          // commands waiting to be driven
  out_item_t alloc_results [$];  // expected results, oldest first
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned in_gap_left = 0;
  int unsigned out_hold_left = 0;
  bit in_burst = 1'b0;   // no sender gaps while set
  bit out_burst = 1'b0;  // no receiver stalls while set

  // Applies one accepted command to the shadow and returns the result it owes.
  function automatic out_item_t apply_command(in_item_t cmd);
    out_item_t            res;
    logic [ADDR_BITS-1:0] addr;
    logic [ADDR_BITS-1:0] nframes;
    logic [ADDR_BITS-1:0] k;
    res = '0;
    res.status = ST_OK;
    case (cmd.command)
      CMD_PUSH: begin
        if (held >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          frame_mem[held] = cmd.frame_address;
          held++;
        end
      end
      CMD_POP: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          held--;
          res.mapped_address = frame_mem[held] + va_offset;
        end
      end
      CMD_REGION: begin
        // Frame count is length / frame size, clipped to the per-region cap.
        nframes = cmd.region_length >> FRAME_SHIFT;
        if (nframes > ADDR_BITS'(frame_cap)) nframes = ADDR_BITS'(frame_cap);
        addr = cmd.frame_address;
        for (k = 0; k < nframes && res.status == ST_OK; k++) begin
          if (held >= STACK_DEPTH) begin
            res.status = ST_FULL;  // remainder of the region is dropped
          end else begin
            frame_mem[held] = addr;
            held++;
            addr = addr + ADDR_BITS'(FRAME_BYTES);  // wraps modulo 2^64
          end
        end
      end
      default: ;
    endcase
    res.free_count = CNT_W'(held);
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  function automatic in_item_t cmd_item(logic [1:0] op, logic [ADDR_BITS-1:0] addr,
                                        logic [ADDR_BITS-1:0] len);
    in_item_t it;
    it.command = op;
    it.frame_address = addr;
    it.region_length = len;
    return it;
  endfunction

  // Random command; the mix steers the frame count toward [lo, hi].
  function automatic in_item_t random_cmd(int unsigned lo, int unsigned hi);
    in_item_t    it;
    int unsigned grow_pct;
    it = cmd_item(CMD_NOP, {$urandom, $urandom}, {$urandom, $urandom});
    grow_pct = (held < lo) ? 75 : (held > hi) ? 15 : 45;
    if ($urandom_range(99) < 4) return it;
    if ($urandom_range(99) < grow_pct) begin
      if ($urandom_range(9) < 3) begin
        it.command = CMD_REGION;
        // Huge lengths only where the cap or the free room keeps them cheap.
        if (!((frame_cap <= 64 || held + 100 > STACK_DEPTH) && $urandom_range(4) == 0))
          it.region_length = (64'($urandom_range(12)) << FRAME_SHIFT) |
                             64'($urandom_range(FRAME_BYTES - 1));
        if ($urandom_range(15) == 0)
          it.frame_address = '1 - 64'($urandom_range(5 * FRAME_BYTES));
      end else begin
        it.command = CMD_PUSH;
      end
    end else begin
      it.command = CMD_POP;
    end
    return it;
  endfunction

  task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued commands, one transaction at a time, with gaps.
  // The shadow is updated at the edge where a command transaction completes.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap_left = 0;
    end else begin
      if (in_valid && in_ready) alloc_results.push_back(apply_command(in_data));
      // Payload may only change once the current transaction is done.
      if (!in_valid || in_ready) begin
        if (in_gap_left != 0) begin
          in_gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          in_data <= cmd_q.pop_front();
          in_valid <= 1'b1;
          in_gap_left = in_burst ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transaction against the oldest expectation,
  // then stalls out_ready for a random while.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (alloc_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, actual %h %h %h", $time,
                   out_data.mapped_address, out_data.status, out_data.free_count);
        end else begin
          want = alloc_results.pop_front();
          if (out_data.mapped_address !== want.mapped_address)
            report("mapped_address", want.mapped_address, out_data.mapped_address);
          if (out_data.status !== want.status)
            report("status", 64'(want.status), 64'(out_data.status));
          if (out_data.free_count !== want.free_count)
            report("free_count", 64'(want.free_count), 64'(out_data.free_count));
        end
        out_hold_left = out_burst ? 0 : pick_gap();
      end
      if (out_hold_left != 0) begin
        out_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, alloc_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencing. Queue handling runs on the falling edge so it never
  // races the driver, which pops on the rising edge.
  // ---------------------------------------------------------------------------
  task automatic send(in_item_t it);
    @(negedge clk);
    while (cmd_q.size() >= 2) @(negedge clk);
    cmd_q.push_back(it);
  endtask

  // Wait until every transaction is done and its result checked, then let the
  // block settle before touching a register.
  task automatic drain();
    do @(negedge clk);
    while (cmd_q.size() != 0 || in_valid || alloc_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Registers are only written while the block is idle.
  task automatic write_reg(logic [0:0] idx, logic [ADDR_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_VIRTUAL_OFFSET) va_offset = val;
    else frame_cap = val[CNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int unsigned n, int unsigned lo, int unsigned hi,
                           int unsigned pause_odds);
    repeat (n) begin
      send(random_cmd(lo, hi));
      // Occasionally hold the sender until everything outstanding has come back.
      if (pause_odds != 0 && $urandom_range(pause_odds - 1) == 0) drain();
    end
  endtask

  task automatic set_phase(logic [ADDR_BITS-1:0] offs, logic [CNT_W-1:0] cap,
                           bit in_b, bit out_b);
    drain();
    write_reg(CFG_VIRTUAL_OFFSET, offs);
    write_reg(CFG_REGION_FRAME_CAP, ADDR_BITS'(cap));
    in_burst = in_b;
    out_burst = out_b;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty pop, address extremes, no-op, empty again, short regions,
    // region whose frame addresses wrap past the top of the address space.
    send(cmd_item(CMD_POP, '0, '0));
    send(cmd_item(CMD_PUSH, '0, '1));
    send(cmd_item(CMD_PUSH, '1, '0));
    send(cmd_item(CMD_NOP, {$urandom, $urandom}, {$urandom, $urandom}));
    send(cmd_item(CMD_POP, '1, '1));
    send(cmd_item(CMD_POP, '0, '0));
    send(cmd_item(CMD_POP, '0, '0));
    send(cmd_item(CMD_REGION, {$urandom, $urandom}, '0));
    send(cmd_item(CMD_REGION, {$urandom, $urandom}, 64'(FRAME_BYTES - 1)));
    send(cmd_item(CMD_REGION, 64'hFFFF_FFFF_FFFF_E000, 64'(3 * FRAME_BYTES + 5)));
    repeat (3) send(cmd_item(CMD_POP, '0, '0));
    send(cmd_item(CMD_PUSH, {$urandom, $urandom}, '0));

    // Zero cap: a region pushes nothing. Cap of one: a huge region pushes one.
    drain();
    write_reg(CFG_REGION_FRAME_CAP, '0);
    send(cmd_item(CMD_REGION, {$urandom, $urandom}, 64'(5 * FRAME_BYTES)));
    drain();
    write_reg(CFG_REGION_FRAME_CAP, 64'd1);
    send(cmd_item(CMD_REGION, {$urandom, $urandom}, '1));
    repeat (2) send(cmd_item(CMD_POP, '0, '0));

    // Largest offset: mapped address wraps modulo 2^64.
    drain();
    write_reg(CFG_VIRTUAL_OFFSET, '1);
    send(cmd_item(CMD_PUSH, 64'd1, '0));
    repeat (2) send(cmd_item(CMD_POP, '0, '0));

    // Random phases at several register settings and count ranges.
    set_phase('1, 16'd16, 1'b0, 1'b0);
    run_phase(400, 0, 8, 0);
    set_phase({$urandom, $urandom}, 16'd1, 1'b1, 1'b1);  // no idling at all
    run_phase(300, 20, 60, 0);
    set_phase(64'd1, 16'd64, 1'b0, 1'b0);
    run_phase(400, 0, 200, 60);
    set_phase({$urandom, $urandom}, 16'd0, 1'b1, 1'b0);
    run_phase(250, 0, 30, 0);
    set_phase('0, 16'd8, 1'b0, 1'b1);
    run_phase(200, 10, 100, 0);

    // Fill toward full: reset cap limits one region, the widest cap then runs
    // into the full stack and drops the rest.
    set_phase({$urandom, $urandom}, CAP_RESET, 1'b0, 1'b0);
    send(cmd_item(CMD_REGION, {$urandom, $urandom}, '1));
    drain();
    write_reg(CFG_REGION_FRAME_CAP, 64'hFFFF);
    send(cmd_item(CMD_REGION, {$urandom, $urandom}, '1));
    send(cmd_item(CMD_PUSH, {$urandom, $urandom}, '0));
    send(cmd_item(CMD_POP, '0, '0));
    send(cmd_item(CMD_PUSH, {$urandom, $urandom}, '0));
    send(cmd_item(CMD_PUSH, {$urandom, $urandom}, '0));

    // Cap equal to the stack depth, then random traffic hovering at the full mark.
    set_phase({$urandom, $urandom}, COUNT_FULL, 1'b0, 1'b0);
    send(cmd_item(CMD_POP, '0, '0));
    send(cmd_item(CMD_REGION, {$urandom, $urandom}, '1));
    run_phase(150, STACK_DEPTH - 40, STACK_DEPTH, 0);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && alloc_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
